// File: rtl/pfa_pkg.sv
`timescale 1ns / 1ps
package pfa_pkg;

  localparam int MAX_PHASE_BINS = 64;
  localparam int LON_BINS       = 1024;
  localparam int PB_W           = $clog2(MAX_PHASE_BINS);
  localparam int LON_W          = $clog2(LON_BINS);
  localparam int ADDR_W         = PB_W + LON_W;
  localparam int CELLS          = MAX_PHASE_BINS * LON_BINS;

  localparam logic signed [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SUM_MIN = {1'b1, {47{1'b0}}};

  typedef enum logic [1:0] {
    CMD_ACC   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_TURNS  = 3'd0,
    REG_OFFSET = 3'd1,
    REG_SLOPE  = 3'd2,
    REG_BINS   = 3'd3,
    REG_NOINT  = 3'd4,
    REG_NONORM = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_RD,
    ST_UPD,
    ST_WR,
    ST_RRD,
    ST_RDAT,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [19:0]        pulse_index;
    logic [9:0]         lon_bin;
    logic signed [15:0] sample;
    logic [5:0]         phase_bin;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] value;
    logic [31:0]        total_weight;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// File: rtl/phase_fold_accumulator.sv
`timescale 1ns / 1ps
// Phase fold accumulator.
// Input items arrive on in_valid/in_ready with an in_item_t payload. Command
// accumulate adds the weighted sample into one or two phase bins of the grid,
// read returns one out_item_t on out_valid/out_ready, clear zeroes one entry.
// Configuration registers are written on cfg_valid/cfg_ready by index.
// One item is processed at a time. An accumulate forms the phase and bin
// products on one shared 25x25 multiplier (MUL1, MUL2, MUL3), then updates
// each bin by read, multiply/add and write steps (RD, UPD, WR) on the grid
// memories, and goes back to idle.
// A read passes through RRD and RDAT, and through a bit-serial divider when a
// mean is formed. A clear is written straight from idle.
// After reset the grid memories are swept to zero, one entry per cycle over
// all 65536 entries, with in_ready low; configuration writes are taken throughout.
// A finished result waits in one output register. While the receiver stalls,
// accumulates and clears go on, and the next read waits for the register.
module phase_fold_accumulator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfa_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pfa_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);

  // Configuration registers.
  logic [23:0]        turns_r, offset_r;
  logic signed [23:0] slope_r;
  logic [6:0]         bins_r;
  logic               noint_r, nonorm_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turns_r  <= '0;
      offset_r <= '0;
      slope_r  <= '0;
      bins_r   <= 7'd16;
      noint_r  <= 1'b0;
      nonorm_r <= 1'b0;
    end else if (cfg_valid) begin
      case (pfa_pkg::reg_idx_t'(cfg_index))
        pfa_pkg::REG_TURNS:  turns_r  <= cfg_data;
        pfa_pkg::REG_OFFSET: offset_r <= cfg_data;
        pfa_pkg::REG_SLOPE:  slope_r  <= cfg_data;
        pfa_pkg::REG_BINS:   bins_r   <= cfg_data[6:0];
        pfa_pkg::REG_NOINT:  noint_r  <= cfg_data[0];
        pfa_pkg::REG_NONORM: nonorm_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective bin count.
  logic [6:0] ebins;
  always_comb begin
    if (bins_r == '0) ebins = 7'd1;
    else if (bins_r > 7'(pfa_pkg::MAX_PHASE_BINS)) ebins = 7'(pfa_pkg::MAX_PHASE_BINS);
    else ebins = bins_r;
  end

  // Grid memories.
  logic signed [47:0] sum_mem [pfa_pkg::CELLS];
  logic [31:0]        wt_mem  [pfa_pkg::CELLS];

  pfa_pkg::state_t state_r, state_nxt;
  pfa_pkg::in_item_t item_r, item_nxt;
  logic [pfa_pkg::ADDR_W:0]   clr_r, clr_nxt;
  logic [24:0]        acc_r, acc_nxt;
  logic [30:0]        scaled_r, scaled_nxt;
  logic [5:0]         jn_r, jn_nxt;
  logic [16:0]        w_r, w_nxt;
  logic               second_r, second_nxt;
  logic signed [47:0] rsum_r;
  logic [31:0]        rwt_r;
  logic signed [47:0] nsum_r, nsum_nxt;
  pfa_pkg::out_item_t out_r, out_nxt;
  logic               ovalid_r, ovalid_nxt;

  // Shared multiplier: 25 x 25 signed.
  logic signed [24:0] ma, mb;
  logic signed [49:0] mp;
  assign mp = ma * mb;

  logic [pfa_pkg::ADDR_W-1:0] addr;
  logic                       mem_we;
  logic signed [47:0]         wsum;
  logic [31:0]                wwt;
  logic signed [49:0]         sadd;
  logic [32:0]                wadd;
  logic [30:0]                sc_full;
  logic                       out_free;
  logic                       dv_start;
  pfa_pkg::div_ctl_t          dv_ctl;
  logic signed [47:0]         dv_q;

  pfa_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start),
    .dividend({rsum_r, 8'd0}), .divisor(rwt_r),
    .ctl(dv_ctl), .quotient(dv_q)
  );

  assign sadd = 50'(nsum_r) + mp;
  assign wadd = 33'(rwt_r) + 33'(w_r);
  assign sc_full = mp[30:0];

  // The output register can take a new result when empty or being taken.
  assign out_free = !ovalid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    clr_nxt    = clr_r;
    acc_nxt    = acc_r;
    scaled_nxt = scaled_r;
    jn_nxt     = jn_r;
    w_nxt      = w_r;
    second_nxt = second_r;
    nsum_nxt   = nsum_r;
    out_nxt    = out_r;
    ovalid_nxt = ovalid_r;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    wsum       = '0;
    wwt        = '0;
    dv_start   = 1'b0;
    ma         = '0;
    mb         = '0;
    addr       = {item_r.phase_bin, item_r.lon_bin};
    // A result taken by the receiver empties the output register.
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    case (state_r)
      pfa_pkg::ST_IDLE: begin
        if (!clr_r[pfa_pkg::ADDR_W]) begin
          // Clearing sweep after reset.
          mem_we  = 1'b1;
          addr    = clr_r[pfa_pkg::ADDR_W-1:0];
          clr_nxt = clr_r + 1'b1;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            item_nxt = in_data;
            case (pfa_pkg::cmd_t'(in_data.command))
              pfa_pkg::CMD_ACC:   state_nxt = pfa_pkg::ST_MUL1;
              pfa_pkg::CMD_READ:  state_nxt = pfa_pkg::ST_RRD;
              pfa_pkg::CMD_CLEAR: begin
                mem_we = 1'b1;
                addr   = {in_data.phase_bin, in_data.lon_bin};
              end
              default: ;
            endcase
          end
        end
      end
      // pulse * turns + offset
      pfa_pkg::ST_MUL1: begin
        ma = 25'({5'd0, item_r.pulse_index});
        mb = 25'({1'b0, turns_r});
        acc_nxt = 25'(mp[23:0]) + 25'(offset_r);
        state_nxt = pfa_pkg::ST_MUL2;
      end
      // minus slope * lon
      pfa_pkg::ST_MUL2: begin
        ma = 25'(slope_r);
        mb = 25'({15'd0, item_r.lon_bin});
        acc_nxt = 25'(acc_r[23:0]) - 25'(mp[23:0]);
        state_nxt = pfa_pkg::ST_MUL3;
      end
      // scale to bins and choose weights
      pfa_pkg::ST_MUL3: begin
        ma = 25'({1'b0, acc_r[23:0]});
        mb = 25'({18'd0, ebins});
        scaled_nxt = sc_full;
        if (noint_r) w_nxt = 17'h10000;
        else w_nxt = 17'h10000 - 17'(sc_full[23:8]);
        jn_nxt = (7'(sc_full[29:24]) + 7'd1 >= ebins) ? 6'd0 : 6'(sc_full[29:24] + 6'd1);
        second_nxt = 1'b0;
        state_nxt = pfa_pkg::ST_RD;
      end
      pfa_pkg::ST_RD: begin
        state_nxt = pfa_pkg::ST_UPD;
      end
      // weighted add with saturation
      pfa_pkg::ST_UPD: begin
        ma = 25'(w_r);
        mb = 25'(item_r.sample);
        nsum_nxt = rsum_r;
        state_nxt = pfa_pkg::ST_WR;
      end
      pfa_pkg::ST_WR: begin
        ma = 25'(w_r);
        mb = 25'(item_r.sample);
        mem_we = 1'b1;
        addr = second_r ? {jn_r, item_r.lon_bin} : {scaled_r[29:24], item_r.lon_bin};
        if (sadd > 50'(pfa_pkg::SUM_MAX)) wsum = pfa_pkg::SUM_MAX;
        else if (sadd < 50'(pfa_pkg::SUM_MIN)) wsum = pfa_pkg::SUM_MIN;
        else wsum = sadd[47:0];
        wwt = wadd[32] ? 32'hFFFF_FFFF : wadd[31:0];
        if (second_r || noint_r) begin
          state_nxt = pfa_pkg::ST_IDLE;
        end else begin
          second_nxt = 1'b1;
          w_nxt = 17'(scaled_r[23:8]);
          state_nxt = pfa_pkg::ST_RD;
        end
      end
      pfa_pkg::ST_RRD: state_nxt = pfa_pkg::ST_RDAT;
      // A mean goes to the divider; a raw sum, also for a zero weight, waits for the output register.
      pfa_pkg::ST_RDAT: begin
        if (!nonorm_r && rwt_r != '0) begin
          dv_start = 1'b1;
          state_nxt = pfa_pkg::ST_DIV;
        end else if (out_free) begin
          out_nxt.value = rsum_r;
          out_nxt.total_weight = rwt_r;
          ovalid_nxt = 1'b1;
          state_nxt = pfa_pkg::ST_IDLE;
        end
      end
      pfa_pkg::ST_DIV: begin
        if (dv_ctl.done) begin
          if (out_free) begin
            out_nxt.value = dv_q;
            out_nxt.total_weight = rwt_r;
            ovalid_nxt = 1'b1;
            state_nxt = pfa_pkg::ST_IDLE;
          end else begin
            state_nxt = pfa_pkg::ST_OUT;
          end
        end
      end
      // The quotient is held by the idle divider until the register frees.
      pfa_pkg::ST_OUT: begin
        if (out_free) begin
          out_nxt.value = dv_q;
          out_nxt.total_weight = rwt_r;
          ovalid_nxt = 1'b1;
          state_nxt = pfa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pfa_pkg::ST_IDLE;
    endcase
  end

  // Memory port: read address follows the bin being worked on.
  logic [pfa_pkg::ADDR_W-1:0] raddr;
  assign raddr = (state_r == pfa_pkg::ST_RRD) ? {item_r.phase_bin, item_r.lon_bin} :
                 second_r ? {jn_r, item_r.lon_bin} : {scaled_r[29:24], item_r.lon_bin};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[addr] <= wsum;
      wt_mem[addr]  <= wwt;
    end
    if (state_r == pfa_pkg::ST_RD || state_r == pfa_pkg::ST_RRD) begin
      rsum_r <= sum_mem[raddr];
      rwt_r  <= wt_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pfa_pkg::ST_IDLE;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
    end
    item_r   <= item_nxt;
    acc_r    <= acc_nxt;
    scaled_r <= scaled_nxt;
    jn_r     <= jn_nxt;
    w_r      <= w_nxt;
    second_r <= second_nxt;
    nsum_r   <= nsum_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_data  = out_r;

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // No item is taken while the clearing sweep runs.
  assert property (@(posedge clk) disable iff (!rst_n)
    !clr_r[pfa_pkg::ADDR_W] |-> !in_ready) else $error("item taken during clear sweep");

  // The divider only runs while a read waits on it.
  assert property (@(posedge clk) disable iff (!rst_n)
    dv_ctl.busy |-> state_r == pfa_pkg::ST_DIV) else $error("divider busy out of place");

endmodule

// File: rtl/pfa_divider.sv
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle, 56 quotient bits per divide.
module pfa_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [55:0] dividend,
  input  logic [31:0]        divisor,
  output pfa_pkg::div_ctl_t  ctl,
  output logic signed [47:0] quotient
);

  logic [55:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [55:0] mag;
  logic signed [56:0] sq;

  assign mag = dividend[55] ? 56'(-dividend) : 56'(dividend);

  // One shift-subtract step per cycle.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], q_r[55]} - {1'b0, dvs_r};
    if (start) begin
      q_nxt    = mag;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      neg_nxt  = dividend[55];
      cnt_nxt  = 6'd55;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[54:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[55]};
        q_nxt   = {q_r[54:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

  // Sign restore and saturation to 48 bits.
  always_comb begin
    sq = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    if (sq > 57'(pfa_pkg::SUM_MAX)) quotient = pfa_pkg::SUM_MAX;
    else if (sq < 57'(pfa_pkg::SUM_MIN)) quotient = pfa_pkg::SUM_MIN;
    else quotient = sq[47:0];
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;

endmodule
